// ===== src/q6k_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q6k_pkg: shared types and constants of the Q6_K x Q8_K dot product
// Holds the block job word passed from the beat unit to the fold unit,
// the operation codes of an input word and the fp32 constants.
// ----------------------------------------------------------------------------
package q6k_pkg;

  // Default number of closed blocks that may wait for the fold unit.
  localparam int unsigned JobDepthDefault = 2;

  // Operation code of an input word.
  typedef enum logic {
    OP_HEADER = 1'b0,
    OP_DATA   = 1'b1
  } q6k_op_e;

  // fp32 quiet bit and the default NaN of the float datapath.
  localparam logic [31:0] QuietBit   = 32'h0040_0000;
  localparam logic [31:0] DefaultNan = 32'hFFC0_0000;

  // One closed block: exact integer sum and the scales that go with it.
  typedef struct packed {
    logic [31:0] block_sum;
    logic [15:0] weight_scale;
    logic [31:0] act_scale;
    logic        end_of_row;
  } q6k_job_t;

endpackage

// ===== src/q6k_beat_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q6k_beat_if / q6k_dot_if: valid/ready channels of the dot product
// q6k_beat_if carries header and data words, q6k_dot_if carries results.
// ----------------------------------------------------------------------------
interface q6k_beat_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  low_nibbles_a;
  logic [7:0]  low_nibbles_b;
  logic [7:0]  high_bits;
  logic [31:0] acts;
  logic [31:0] group_scales;
  logic [15:0] weight_scale;
  logic [31:0] act_scale;
  logic        end_of_block;
  logic        end_of_row;

  modport source (
    output valid, op, low_nibbles_a, low_nibbles_b, high_bits, acts, group_scales,
           weight_scale, act_scale, end_of_block, end_of_row,
    input  ready
  );
  modport sink (
    input  valid, op, low_nibbles_a, low_nibbles_b, high_bits, acts, group_scales,
           weight_scale, act_scale, end_of_block, end_of_row,
    output ready
  );
endinterface

interface q6k_dot_if;
  logic        valid;
  logic        ready;
  logic [31:0] dot_result;

  modport source (output valid, dot_result, input ready);
  modport sink (input valid, dot_result, output ready);
endinterface

// ===== src/q6k_beat_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q6k_beat_unit: accepts words, rebuilds weights, sums each block exactly
// Stage one rebuilds the 6-bit weights and forms scale*(weight-32); stage
// two multiplies by the activations, folds into the block sum and pushes a
// job at block or row end.
// ----------------------------------------------------------------------------
module q6k_beat_unit
  import q6k_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  q6k_beat_if.sink  beat_i,
  output q6k_job_t  job_o,
  output logic      job_push_o,
  input  logic      job_full_i
);

  localparam logic signed [6:0] WeightOffset = 7'sd32;

  logic                s1_valid_q;
  q6k_op_e             s1_op_q;
  logic                s1_eob_q;
  logic                s1_eor_q;
  logic signed [13:0]  s1_part_q [4];
  logic signed [7:0]   s1_act_q [4];
  logic [15:0]         s1_ws_q;
  logic [31:0]         s1_as_q;

  logic [31:0]         block_sum_q;
  logic [15:0]         held_ws_q;
  logic [31:0]         held_as_q;

  logic [5:0]          weight [4];
  logic signed [6:0]   centered [4];
  logic signed [13:0]  part_d [4];
  logic signed [20:0]  prod [4];
  logic signed [22:0]  beat_sum;
  logic [31:0]         sum_d;
  logic                accept;
  logic                need_push;
  logic                s1_fire;

  // Rebuild the four weights from nibble and high-bit bytes.
  always_comb begin : rebuild
    weight[0] = {beat_i.high_bits[1:0], beat_i.low_nibbles_a[3:0]};
    weight[1] = {beat_i.high_bits[3:2], beat_i.low_nibbles_b[3:0]};
    weight[2] = {beat_i.high_bits[5:4], beat_i.low_nibbles_a[7:4]};
    weight[3] = {beat_i.high_bits[7:6], beat_i.low_nibbles_b[7:4]};
    for (int k = 0; k < 4; k++) begin
      centered[k] = $signed({1'b0, weight[k]}) - WeightOffset;
      part_d[k]   = $signed({{6{beat_i.group_scales[8*k+7]}}, beat_i.group_scales[8*k +: 8]})
                  * $signed({{7{centered[k][6]}}, centered[k]});
    end
  end

  always_comb begin : beat_mac
    beat_sum = '0;
    for (int k = 0; k < 4; k++) begin
      prod[k]  = $signed({{7{s1_part_q[k][13]}}, s1_part_q[k]})
               * $signed({{13{s1_act_q[k][7]}}, s1_act_q[k]});
      beat_sum = beat_sum + $signed({{2{prod[k][20]}}, prod[k]});
    end
    sum_d = block_sum_q + {{9{beat_sum[22]}}, beat_sum};
  end

  assign need_push  = (s1_op_q == OP_DATA) && (s1_eob_q || s1_eor_q);
  assign s1_fire    = s1_valid_q && !(need_push && job_full_i);
  assign beat_i.ready = !s1_valid_q || s1_fire;
  assign accept     = beat_i.valid && beat_i.ready;

  assign job_push_o       = s1_fire && need_push;
  assign job_o.block_sum    = sum_d;
  assign job_o.weight_scale = held_ws_q;
  assign job_o.act_scale    = held_as_q;
  assign job_o.end_of_row   = s1_eor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      block_sum_q <= '0;
      held_ws_q   <= '0;
      held_as_q   <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        if (s1_op_q == OP_HEADER) begin
          held_ws_q <= s1_ws_q;
          held_as_q <= s1_as_q;
        end else if (need_push) begin
          block_sum_q <= '0;
        end else begin
          block_sum_q <= sum_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q  <= q6k_op_e'(beat_i.op);
      s1_eob_q <= beat_i.end_of_block;
      s1_eor_q <= beat_i.end_of_row;
      s1_ws_q  <= beat_i.weight_scale;
      s1_as_q  <= beat_i.act_scale;
      for (int k = 0; k < 4; k++) begin
        s1_part_q[k] <= part_d[k];
        s1_act_q[k]  <= $signed(beat_i.acts[8*k +: 8]);
      end
    end
  end

endmodule

// ===== src/q6k_job_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q6k_job_fifo: short queue of closed blocks
// Decouples the beat unit from the multi-cycle fold unit.
// ----------------------------------------------------------------------------
module q6k_job_fifo
  import q6k_pkg::*;
#(
  parameter int unsigned Depth = JobDepthDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q6k_job_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output q6k_job_t data_o,
  output logic     valid_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  q6k_job_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== src/q6k_fold_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q6k_fold_unit: folds each block into the fp32 row accumulator
// One shared multiply / align / add / normalize / round datapath runs three
// passes per block: scale product, integer-to-float, fused multiply-add.
// ----------------------------------------------------------------------------
module q6k_fold_unit
  import q6k_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q6k_job_t  job_i,
  input  logic      job_valid_i,
  output logic      job_pop_o,
  q6k_dot_if.source dot_o
);

  localparam int unsigned       WideW     = 80;
  localparam logic signed [11:0] RoundBias = 12'(WideW + 126);
  localparam logic signed [11:0] DenormExp = 12'sd1 - RoundBias;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_LOAD   = 10'b00_0000_0010,
    ST_MUL    = 10'b00_0000_0100,
    ST_PREP   = 10'b00_0000_1000,
    ST_ALIGN  = 10'b00_0001_0000,
    ST_ADD    = 10'b00_0010_0000,
    ST_NORM   = 10'b00_0100_0000,
    ST_DENORM = 10'b00_1000_0000,
    ST_ROUND  = 10'b01_0000_0000,
    ST_EMIT   = 10'b10_0000_0000
  } fold_state_e;

  typedef enum logic [1:0] {
    PH_SCALE = 2'd0,
    PH_CONV  = 2'd1,
    PH_FOLD  = 2'd2
  } fold_phase_e;

  typedef struct packed {
    logic [23:0]        man;
    logic signed [11:0] exp;
  } unp_t;

  function automatic unp_t unpack32(input logic [31:0] f);
    unp_t u;
    if (f[30:23] == 8'd0) begin
      u.man = {1'b0, f[22:0]};
      u.exp = -12'sd149;
    end else begin
      u.man = {1'b1, f[22:0]};
      u.exp = $signed({4'b0, f[30:23]}) - 12'sd150;
    end
    return u;
  endfunction

  function automatic unp_t unpack16(input logic [15:0] h);
    unp_t u;
    if (h[14:10] == 5'd0) begin
      u.man = {14'b0, h[9:0]};
      u.exp = -12'sd24;
    end else begin
      u.man = {13'b0, 1'b1, h[9:0]};
      u.exp = $signed({7'b0, h[14:10]}) - 12'sd25;
    end
    return u;
  endfunction

  fold_state_e        state_q, state_d;
  fold_phase_e        phase_q, phase_d;
  q6k_job_t           job_q;
  logic [31:0]        ds_q;
  logic [31:0]        fsum_q;
  logic [31:0]        acc_q;
  logic               out_valid_q;
  logic [31:0]        out_data_q;

  logic [23:0]        a_man_q, b_man_q, c_man_q;
  logic signed [11:0] a_exp_q, b_exp_q, c_exp_q;
  logic               p_sign_q, c_sign_q;
  logic [47:0]        prod_q;
  logic signed [11:0] prod_exp_q;

  logic [WideW-1:0]   big_q, sml_q;
  logic signed [11:0] big_exp_q, sml_exp_q;
  logic               big_sign_q, sml_sign_q;
  logic               st_q;
  logic               zero_sign_q;

  // Operand classification
  logic [31:0]        a_bits;
  logic               a_nan, a_inf, a_zero, b_nan, b_inf, b_zero, c_nan, c_inf;
  logic               p_sign;
  unp_t               ua, ub, uc;
  logic [31:0]        b_nan_val;
  logic               ld_special;
  logic [31:0]        ld_value;
  logic [31:0]        si_mag;

  logic signed [11:0] al_diff;
  logic signed [11:0] dn_bexp;
  logic signed [11:0] dn_short;
  logic               add_ge;
  logic [23:0]        rnd_man;
  logic [7:0]         rnd_field;
  logic               rnd_inc;
  logic [30:0]        rnd_bits;
  logic [31:0]        rnd_value;

  logic               fin_valid;
  logic [31:0]        fin_value;
  logic               emit_go;

  always_comb begin : classify
    a_bits    = (phase_q == PH_FOLD) ? ds_q : job_q.act_scale;
    a_nan     = (&a_bits[30:23]) && (|a_bits[22:0]);
    a_inf     = (&a_bits[30:23]) && !(|a_bits[22:0]);
    a_zero    = !(|a_bits[30:0]);
    ua        = unpack32(a_bits);
    uc        = unpack32(acc_q);
    c_nan     = (&acc_q[30:23]) && (|acc_q[22:0]);
    c_inf     = (&acc_q[30:23]) && !(|acc_q[22:0]);
    b_nan_val = {job_q.weight_scale[15], 8'hFF, job_q.weight_scale[9:0], 13'b0} | QuietBit;
    if (phase_q == PH_FOLD) begin
      b_nan  = 1'b0;
      b_inf  = 1'b0;
      b_zero = !(|fsum_q[30:0]);
      ub     = unpack32(fsum_q);
      p_sign = a_bits[31] ^ fsum_q[31];
    end else begin
      b_nan  = (&job_q.weight_scale[14:10]) && (|job_q.weight_scale[9:0]);
      b_inf  = (&job_q.weight_scale[14:10]) && !(|job_q.weight_scale[9:0]);
      b_zero = !(|job_q.weight_scale[14:0]);
      ub     = unpack16(job_q.weight_scale);
      p_sign = a_bits[31] ^ job_q.weight_scale[15];
    end

    // NaN takes the first operand, invalid cases give the default NaN
    ld_special = 1'b1;
    ld_value   = DefaultNan;
    if (phase_q == PH_CONV) begin
      ld_special = 1'b0;
    end else if (a_nan) begin
      ld_value = a_bits | QuietBit;
    end else if (b_nan) begin
      ld_value = b_nan_val;
    end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
      ld_value = DefaultNan;
    end else if ((phase_q == PH_FOLD) && c_nan) begin
      ld_value = acc_q | QuietBit;
    end else if (a_inf || b_inf) begin
      if ((phase_q == PH_FOLD) && c_inf && (acc_q[31] != p_sign)) begin
        ld_value = DefaultNan;
      end else begin
        ld_value = {p_sign, 8'hFF, 23'b0};
      end
    end else if ((phase_q == PH_FOLD) && c_inf) begin
      ld_value = acc_q;
    end else begin
      ld_special = 1'b0;
    end

    si_mag = job_q.block_sum[31] ? (~job_q.block_sum + 32'd1) : job_q.block_sum;
  end

  always_comb begin : wide_math
    al_diff   = big_exp_q - sml_exp_q;
    dn_bexp   = big_exp_q + RoundBias;
    dn_short  = 12'sd1 - dn_bexp;
    add_ge    = (big_q >= sml_q);
    rnd_man   = big_q[WideW-1 -: 24];
    rnd_field = big_q[WideW-1] ? dn_bexp[7:0] : 8'd0;
    rnd_inc   = big_q[WideW-25] & ((|big_q[WideW-26:0]) | st_q | rnd_man[0]);
    rnd_bits  = {rnd_field, rnd_man[22:0]} + {30'b0, rnd_inc};
    rnd_value = (dn_bexp >= 12'sd255) ? {big_sign_q, 8'hFF, 23'b0} : {big_sign_q, rnd_bits};
  end

  assign emit_go = !out_valid_q || dot_o.ready;

  always_comb begin : fsm
    state_d   = state_q;
    phase_d   = phase_q;
    fin_valid = 1'b0;
    fin_value = rnd_value;
    job_pop_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          phase_d   = PH_SCALE;
          state_d   = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (phase_q == PH_CONV) begin
          state_d = ST_PREP;
        end else if (ld_special) begin
          fin_valid = 1'b1;
          fin_value = ld_value;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:   state_d = ST_PREP;
      ST_PREP:  state_d = ST_ALIGN;
      ST_ALIGN: begin
        if ((al_diff == 12'sd0) || (sml_q == '0)) begin
          state_d = ST_ADD;
        end else if ((big_q[WideW-2] == 1'b1) && (sml_q[WideW-1:1] == '0)) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD:   state_d = ST_NORM;
      ST_NORM: begin
        if (big_q == '0) begin
          fin_valid = 1'b1;
          fin_value = {zero_sign_q, 31'b0};
        end else if (big_q[WideW-1]) begin
          state_d = ST_DENORM;
        end
      end
      ST_DENORM: begin
        if (dn_bexp >= 12'sd1) begin
          state_d = ST_ROUND;
        end else if (big_q == '0) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: fin_valid = 1'b1;
      ST_EMIT: begin
        if (emit_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Advance to the next pass when a pass produces its fp32 value; the fold pass ends the block
    if (fin_valid) begin
      case (phase_q)
        PH_SCALE: begin
          phase_d = PH_CONV;
          state_d = ST_LOAD;
        end
        PH_CONV: begin
          phase_d = PH_FOLD;
          state_d = ST_LOAD;
        end
        default: begin
          phase_d = PH_SCALE;
          state_d = job_q.end_of_row ? ST_EMIT : ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_SCALE;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      if (fin_valid && (phase_q == PH_FOLD)) begin
        acc_q <= fin_value;
      end
      if ((state_q == ST_EMIT) && emit_go) begin
        out_valid_q <= 1'b1;
        acc_q       <= '0;
      end else if (dot_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
    if (fin_valid) begin
      case (phase_q)
        PH_SCALE: ds_q   <= fin_value;
        PH_CONV:  fsum_q <= fin_value;
        default:  ;
      endcase
    end
    if ((state_q == ST_EMIT) && emit_go) begin
      out_data_q <= acc_q;
    end
    unique case (state_q)
      ST_LOAD: begin
        a_man_q  <= ua.man;
        a_exp_q  <= ua.exp;
        b_man_q  <= ub.man;
        b_exp_q  <= ub.exp;
        if (phase_q == PH_CONV) begin
          prod_q     <= {16'b0, si_mag};
          prod_exp_q <= '0;
          p_sign_q   <= job_q.block_sum[31];
          c_man_q    <= '0;
          c_exp_q    <= '0;
          c_sign_q   <= job_q.block_sum[31];
        end else if (phase_q == PH_FOLD) begin
          p_sign_q <= p_sign;
          c_man_q  <= uc.man;
          c_exp_q  <= uc.exp;
          c_sign_q <= acc_q[31];
        end else begin
          // a bare product: addend is a zero of the product's sign
          p_sign_q <= p_sign;
          c_man_q  <= '0;
          c_exp_q  <= '0;
          c_sign_q <= p_sign;
        end
      end
      ST_MUL: begin
        prod_q     <= a_man_q * b_man_q;
        prod_exp_q <= a_exp_q + b_exp_q;
      end
      ST_PREP: begin
        st_q        <= 1'b0;
        zero_sign_q <= (p_sign_q == c_sign_q) ? p_sign_q : 1'b0;
        // Larger exponent goes high; a zero operand always goes low
        if ((prod_q == '0) || ((c_man_q != '0) && (c_exp_q >= prod_exp_q))) begin
          big_q      <= {56'b0, c_man_q};
          big_exp_q  <= c_exp_q;
          big_sign_q <= c_sign_q;
          sml_q      <= {32'b0, prod_q};
          sml_exp_q  <= prod_exp_q;
          sml_sign_q <= p_sign_q;
        end else begin
          big_q      <= {32'b0, prod_q};
          big_exp_q  <= prod_exp_q;
          big_sign_q <= p_sign_q;
          sml_q      <= {56'b0, c_man_q};
          sml_exp_q  <= c_exp_q;
          sml_sign_q <= c_sign_q;
        end
      end
      ST_ALIGN: begin
        if ((al_diff == 12'sd0) || (sml_q == '0)) begin
          sml_exp_q <= big_exp_q;
        end else if ((big_q[WideW-2 -: 8] == 8'd0) && (al_diff >= 12'sd8)) begin
          big_q     <= big_q << 8;
          big_exp_q <= big_exp_q - 12'sd8;
        end else if (big_q[WideW-2] == 1'b0) begin
          big_q     <= big_q << 1;
          big_exp_q <= big_exp_q - 12'sd1;
        end else if (sml_q[WideW-1:1] == '0) begin
          // only the sticky jam bit is left: further shifts keep it as is
          sml_exp_q <= big_exp_q;
        end else if (al_diff >= 12'sd8) begin
          sml_q     <= (sml_q >> 8) | {{(WideW-1){1'b0}}, (|sml_q[7:0])};
          sml_exp_q <= sml_exp_q + 12'sd8;
        end else begin
          sml_q     <= (sml_q >> 1) | {{(WideW-1){1'b0}}, sml_q[0]};
          sml_exp_q <= sml_exp_q + 12'sd1;
        end
      end
      ST_ADD: begin
        if (big_sign_q == sml_sign_q) begin
          big_q <= big_q + sml_q;
        end else if (add_ge) begin
          big_q <= big_q - sml_q;
        end else begin
          big_q      <= sml_q - big_q;
          big_sign_q <= sml_sign_q;
        end
      end
      ST_NORM: begin
        if ((big_q != '0) && !big_q[WideW-1]) begin
          if (big_q[WideW-1 -: 8] == 8'd0) begin
            big_q     <= big_q << 8;
            big_exp_q <= big_exp_q - 12'sd8;
          end else begin
            big_q     <= big_q << 1;
            big_exp_q <= big_exp_q - 12'sd1;
          end
        end
      end
      ST_DENORM: begin
        if (dn_bexp < 12'sd1) begin
          if (big_q == '0) begin
            big_exp_q <= DenormExp;
          end else if (dn_short >= 12'sd8) begin
            big_q     <= big_q >> 8;
            st_q      <= st_q | (|big_q[7:0]);
            big_exp_q <= big_exp_q + 12'sd8;
          end else begin
            big_q     <= big_q >> 1;
            st_q      <= st_q | big_q[0];
            big_exp_q <= big_exp_q + 12'sd1;
          end
        end
      end
      default: ;
    endcase
  end

  assign dot_o.valid      = out_valid_q;
  assign dot_o.dot_result = out_data_q;

endmodule

// ===== src/q6k_q8k_dot_product.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q6k_q8k_dot_product: Q6_K weight row times Q8_K activations, fp32 result
// Streams headers and data words of one row, sums each superblock exactly
// in integers and folds it into an fp32 row accumulator with one fused
// multiply-add.
// ----------------------------------------------------------------------------
//
//  channel | dir | word                               | accepted when
//  --------+-----+------------------------------------+----------------------
//  beat_i  | in  | header (scales) or data (4 weights) | valid && ready
//  dot_o   | out | fp32 row dot product                | valid && ready
//
// Flow: the beat unit takes one word per cycle, except while it stalls, through
// a two-stage integer pipeline. Each closed block goes to a job queue of JobDepth
// entries; the fold unit runs an iterative align/normalize/denormalize shifter
// three times per block and takes a new block only from its idle state;
// at a row end it passes through an emit state.
// Stalls: the beat unit holds ready low only while a block-end or row-end data word
// waits for a free queue slot; the result sits in its own output register.
// Reset: asynchronous, active low; clears the block sum, held scales,
// the accumulator (+0.0), the queue and all valid flags.
//
module q6k_q8k_dot_product
  import q6k_pkg::*;
#(
  parameter int unsigned JobDepth = JobDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  q6k_beat_if.sink  beat_i,
  q6k_dot_if.source dot_o
);

  q6k_job_t job_in;
  q6k_job_t job_out;
  logic     job_push;
  logic     job_full;
  logic     job_pop;
  logic     job_valid;

  // Front: accept words, rebuild weights, sum each block exactly
  q6k_beat_unit u_beat (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .beat_i     (beat_i),
    .job_o      (job_in),
    .job_push_o (job_push),
    .job_full_i (job_full)
  );

  // Queue of closed blocks between the two sides
  q6k_job_fifo #(
    .Depth (JobDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .valid_o (job_valid)
  );

  // Back: fp32 scale product, int-to-float, fused fold into the accumulator
  q6k_fold_unit u_fold (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .job_valid_i (job_valid),
    .job_pop_o   (job_pop),
    .dot_o       (dot_o)
  );

endmodule
